// ----- hdl/bgc_pkg.sv -----
// Shared widths, constants, codes and types of the bias add and GELU pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bgc_pkg;

    // Stream payload widths.
    localparam int DATA_WIDTH = 24;
    localparam int FRAC_BITS  = 16;
    localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;

    // Chebyshev series.
    localparam int NUM_COEF  = 15;
    localparam int NUM_STEPS = NUM_COEF - 1;

    // Recurrence arithmetic, all in Q30.
    localparam int ACC_W  = 36;
    localparam int X_W    = 32;
    localparam int PROD_W = ACC_W + X_W;
    localparam int SUM_W  = ACC_W + 2;

    // Square and divide-by-72 front end.
    localparam int ZS_W      = 20;
    localparam int SQ_W      = 2 * ZS_W - 2;
    localparam int U_W       = SQ_W - 3;
    localparam int L_W       = 18;
    localparam int H_W       = U_W - L_W;
    localparam int QH_W      = 14;
    localparam int R_W       = 4;
    localparam int V_W       = L_W + R_W;
    localparam int Q_W       = QH_W + L_W;
    localparam int RECIP1_W  = 18;
    localparam int RECIP2_W  = 23;
    localparam int RECIP1_SH = H_W + 4;
    localparam int RECIP2_SH = V_W + 4;

    // Reciprocals of nine, rounded up, exact for H_W and V_W bit dividends.
    localparam logic [RECIP1_W-1:0] RECIP1 = 18'd233017;
    localparam logic [RECIP2_W-1:0] RECIP2 = 23'd7456541;

    localparam logic [SQ_W-1:0]        SQ_BIAS   = SQ_W'(36);
    localparam logic signed [X_W-1:0]  X_ONE     = X_W'(64'sd1 <<< 30);
    localparam logic signed [SUM_W-1:0] ACC_LIMIT = SUM_W'(64'sd1 <<< 34);
    localparam logic signed [31:0]     SIX_Q16   = 32'sd393216;

    // Result selection codes.
    localparam logic [1:0] SEL_SERIES = 2'd0;
    localparam logic [1:0] SEL_ZERO   = 2'd1;
    localparam logic [1:0] SEL_PASS   = 2'd2;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [X_W-1:0]   xval_t;

    // Control that travels beside each item through the pipeline.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [1:0]            sel;
        logic [DATA_WIDTH-1:0] z;
    } bgc_side_t;

    // Series coefficients in Q30, lowest order first.
    localparam acc_t COEF_Q30 [0:NUM_COEF-1] = '{
        36'sd2021573246,
        36'sd1420379261,
        -36'sd313598336,
        36'sd140775408,
        -36'sd73354272,
        36'sd38489056,
        -36'sd19320520,
        36'sd9096215,
        -36'sd3989145,
        36'sd1626444,
        -36'sd617721,
        36'sd218207,
        -36'sd72408,
        36'sd21629,
        -36'sd6365
    };

endpackage

`default_nettype wire

// ----- hdl/bgc_step.sv -----
// One Clenshaw recurrence step: a multiply stage and a round, add and clamp stage.
`timescale 1ns / 1ps
`default_nettype none

module bgc_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               last_step,
    input  bgc_pkg::acc_t      coef,
    input  bgc_pkg::bgc_side_t side_in,
    input  bgc_pkg::xval_t     x_in,
    input  bgc_pkg::acc_t      nxt_in,
    input  bgc_pkg::acc_t      nn_in,
    output bgc_pkg::bgc_side_t side_out,
    output bgc_pkg::xval_t     x_out,
    output bgc_pkg::acc_t      nxt_out,
    output bgc_pkg::acc_t      nn_out
);
    import bgc_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_29 = PROD_W'(1) <<< 28;
    localparam logic signed [PROD_W-1:0] HALF_30 = PROD_W'(1) <<< 29;
    localparam logic signed [SUM_W-1:0]  ACC_NEG = -ACC_LIMIT;

    bgc_side_t                side_a_reg, side_b_reg;
    xval_t                    x_a_reg, x_b_reg;
    acc_t                     nxt_a_reg, nn_a_reg, nxt_b_reg, nn_b_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0] rnd29, rnd30;
    logic signed [SUM_W-1:0]  sum;
    acc_t                     nxt_b_next;

    assign prod_a_next = PROD_W'(x_in) * PROD_W'(nxt_in);

    always_comb begin
        rnd29 = (prod_a_reg + HALF_29) >>> 29;
        rnd30 = (prod_a_reg + HALF_30) >>> 30;
        sum = (last_step ? SUM_W'(rnd30) : SUM_W'(rnd29)) - SUM_W'(nn_a_reg) + SUM_W'(coef);
        if (sum > ACC_LIMIT) begin
            nxt_b_next = ACC_W'(ACC_LIMIT);
        end else if (sum < ACC_NEG) begin
            nxt_b_next = ACC_W'(ACC_NEG);
        end else begin
            nxt_b_next = ACC_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg <= '0;
            side_b_reg <= '0;
        end else if (en) begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
        end
        if (en) begin
            prod_a_reg <= prod_a_next;
            x_a_reg    <= x_in;
            nxt_a_reg  <= nxt_in;
            nn_a_reg   <= nn_in;
            x_b_reg    <= x_a_reg;
            nxt_b_reg  <= nxt_b_next;
            nn_b_reg   <= nxt_a_reg;
        end
    end

    assign side_out = side_b_reg;
    assign x_out    = x_b_reg;
    assign nxt_out  = nxt_b_reg;
    assign nn_out   = nn_b_reg;

endmodule

`default_nettype wire

// ----- hdl/bias_gelu_chebyshev.sv -----
// Top level: bias add with saturation followed by a Chebyshev series GELU.
//
// Each request on the slave stream carries an activation and a bias, both signed
// fixed point with 16 fraction bits. The block adds them, saturates the sum and
// returns its GELU on the master stream in the same format; tlast passes through.
// Results leave in request order, one for every request.
//
// While the skid register is empty, the pipeline takes one request per clock and
// returns one result per clock. An accepted request passes through five front
// stages (add, square, two divide-by-nine stages and the offset), the 14 Clenshaw
// steps, each a multiply stage and an add stage, and one output rounding stage
// before the output register, which drives m_tvalid.
//
// A synchronous low level on aresetn empties the pipeline: all valid bits, those of
// the output and skid registers included, clear, and s_tready is high afterwards.
// When the receiver stalls, the item behind the output register drops into a
// one-entry skid register and the whole pipeline holds. s_tready is low exactly
// while that skid register is full, so no item is lost or repeated; it comes
// from a register and has no combinational path from m_tready.
`timescale 1ns / 1ps
`default_nettype none

module bias_gelu_chebyshev (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // From bit 0: activation_in, bias_in.
    input  logic [bgc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0: gelu_out, then zero fill to a whole byte.
    output logic [bgc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import bgc_pkg::*;

    localparam logic [DATA_WIDTH-1:0] Z_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] Z_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int HALFZ_SH = 29 - FRAC_BITS;
    localparam int OUT_SH   = 30 - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(1) <<< (OUT_SH - 1);
    localparam logic signed [SUM_W-1:0] OUT_MAX =
        SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

    // The pipeline moves as a whole whenever the skid register is empty.
    logic en;

    // Stage 1: bias add and saturation.
    logic signed [DATA_WIDTH:0] sum_wide;
    logic [DATA_WIDTH-1:0]      z1_next;
    bgc_side_t                  side1_reg, side1_next;

    // Stage 2: range check and square.
    logic signed [31:0]         zw;
    logic signed [ZS_W-1:0]     zs;
    logic signed [2*ZS_W-1:0]   sq_full;
    logic [1:0]                 sel2_next;
    bgc_side_t                  side2_reg, side2_next;
    logic [SQ_W-1:0]            sq_reg;

    // Stage 3: first divide-by-nine on the upper part of the square.
    logic [SQ_W-1:0]            sq_biased;
    logic [U_W-1:0]             u;
    logic [H_W+RECIP1_W-1:0]    qh_prod;
    bgc_side_t                  side3_reg;
    logic [H_W-1:0]             h3_reg;
    logic [L_W-1:0]             l3_reg;
    logic [QH_W-1:0]            qh3_reg;

    // Stage 4: remainder and second divide-by-nine.
    logic [H_W-1:0]             nine_qh, rh_full;
    logic [V_W-1:0]             v;
    logic [V_W+RECIP2_W-1:0]    q2_prod;
    bgc_side_t                  side4_reg;
    logic [QH_W-1:0]            qh4_reg;
    logic [L_W-1:0]             q2_reg;

    // Stage 5: series argument x = z*z/18 - 1 in Q30.
    bgc_side_t                  side5_reg;
    xval_t                      x5_reg, x5_next;

    // Clenshaw chain.
    bgc_side_t                  side_c [0:NUM_STEPS];
    xval_t                      x_c    [0:NUM_STEPS];
    acc_t                       nxt_c  [0:NUM_STEPS];
    acc_t                       nn_c   [0:NUM_STEPS];

    // Result stage.
    logic signed [SUM_W-1:0]    t_sum, r_sum;
    logic [DATA_WIDTH-1:0]      series_q16, res_next;
    logic                       res_valid_reg, res_last_reg;
    logic [DATA_WIDTH-1:0]      res_data_reg;

    // Output register and skid register.
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg, out_last_next;
    logic [DATA_WIDTH-1:0]      out_data_reg, out_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    logic                       skid_last_reg, skid_last_next;
    logic [DATA_WIDTH-1:0]      skid_data_reg, skid_data_next;
    logic                       leave, out_fire;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Stage 1.
    always_comb begin
        sum_wide = (DATA_WIDTH+1)'($signed(s_tdata[DATA_WIDTH-1:0]))
                 + (DATA_WIDTH+1)'($signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
        if (sum_wide[DATA_WIDTH] != sum_wide[DATA_WIDTH-1]) begin
            z1_next = sum_wide[DATA_WIDTH] ? Z_MIN : Z_MAX;
        end else begin
            z1_next = sum_wide[DATA_WIDTH-1:0];
        end
        side1_next = '{valid: s_tvalid, last: s_tlast, sel: SEL_SERIES, z: z1_next};
    end

    // Stage 2. Outside the open range of plus or minus six the square is garbage,
    // but the selection code overrides the series there.
    always_comb begin
        zw      = 32'($signed(side1_reg.z));
        zs      = ZS_W'($signed(side1_reg.z));
        sq_full = zs * zs;
        if (zw == 32'sd0 || zw <= -SIX_Q16) begin
            sel2_next = SEL_ZERO;
        end else if (zw >= SIX_Q16) begin
            sel2_next = SEL_PASS;
        end else begin
            sel2_next = SEL_SERIES;
        end
        side2_next     = side1_reg;
        side2_next.sel = sel2_next;
    end

    // Stage 3: u = (z*z + 36) / 8, then the upper bits of u divided by nine.
    always_comb begin
        sq_biased = sq_reg + SQ_BIAS;
        u         = sq_biased[SQ_W-1:3];
        qh_prod   = (H_W+RECIP1_W)'(u[U_W-1:L_W]) * (H_W+RECIP1_W)'(RECIP1);
    end

    // Stage 4: the remainder of the upper bits joins the lower bits for the
    // second division.
    always_comb begin
        nine_qh = (H_W'(qh3_reg) << 3) + H_W'(qh3_reg);
        rh_full = h3_reg - nine_qh;
        v       = {rh_full[R_W-1:0], l3_reg};
        q2_prod = (V_W+RECIP2_W)'(v) * (V_W+RECIP2_W)'(RECIP2);
    end

    assign x5_next = $signed({qh4_reg, q2_reg}) - X_ONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
        end else if (en) begin
            side1_reg <= side1_next;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
        end
        if (en) begin
            sq_reg  <= sq_full[SQ_W-1:0];
            h3_reg  <= u[U_W-1:L_W];
            l3_reg  <= u[L_W-1:0];
            qh3_reg <= qh_prod[RECIP1_SH +: QH_W];
            qh4_reg <= qh3_reg;
            q2_reg  <= q2_prod[RECIP2_SH +: L_W];
            x5_reg  <= x5_next;
        end
    end

    // The highest coefficient seeds the recurrence; the steps then run from the
    // next lower coefficient down to the constant term, which uses the half
    // weight product.
    assign side_c[0] = side5_reg;
    assign x_c[0]    = x5_reg;
    assign nxt_c[0]  = COEF_Q30[NUM_COEF-1];
    assign nn_c[0]   = '0;

    for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
        bgc_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .last_step (i == NUM_STEPS - 1),
            .coef      (COEF_Q30[NUM_COEF-2-i]),
            .side_in   (side_c[i]),
            .x_in      (x_c[i]),
            .nxt_in    (nxt_c[i]),
            .nn_in     (nn_c[i]),
            .side_out  (side_c[i+1]),
            .x_out     (x_c[i+1]),
            .nxt_out   (nxt_c[i+1]),
            .nn_out    (nn_c[i+1])
        );
    end

    // Result stage: add 0.5*z, round to 16 fraction bits, saturate, select.
    always_comb begin
        t_sum = SUM_W'(nxt_c[NUM_STEPS])
              + (SUM_W'($signed(side_c[NUM_STEPS].z)) <<< HALFZ_SH);
        r_sum = (t_sum + OUT_RND) >>> OUT_SH;
        if (r_sum > OUT_MAX) begin
            series_q16 = Z_MAX;
        end else if (r_sum < OUT_MIN) begin
            series_q16 = Z_MIN;
        end else begin
            series_q16 = DATA_WIDTH'(r_sum);
        end
        case (side_c[NUM_STEPS].sel)
            SEL_SERIES: res_next = series_q16;
            SEL_ZERO:   res_next = '0;
            SEL_PASS:   res_next = side_c[NUM_STEPS].z;
            default:    res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= side_c[NUM_STEPS].valid;
        end
        if (en) begin
            res_last_reg <= side_c[NUM_STEPS].last;
            res_data_reg <= res_next;
        end
    end

    // Output register with a one-entry skid register behind it.
    assign leave    = res_valid_reg && en;
    assign out_fire = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_last_next  = skid_last_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_last_next   = skid_last_reg;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_fire) begin
            out_valid_next = leave;
            out_last_next  = res_last_reg;
            out_data_next  = res_data_reg;
        end else if (leave) begin
            skid_valid_next = 1'b1;
            skid_last_next  = res_last_reg;
            skid_data_next  = res_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_last_reg  <= out_last_next;
        out_data_reg  <= out_data_next;
        skid_last_reg <= skid_last_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule

`default_nettype wire

// ----- hdl/bgc_checker.sv -----
// Port-level assertions for the bias add and GELU block, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module bgc_props (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bgc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The input side only closes after the output side stalled with a result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input blocked without an output stall");

    // The input side only reopens after a result was taken.
    a_resume_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> $past(m_tvalid && m_tready))
        else $error("input reopened without a result taken");

endmodule

bind bias_gelu_chebyshev bgc_props u_bgc_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
